[rtl/im2col_pkg.sv]
package im2col_pkg;

  localparam int unsigned CH_W   = 11;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned KER_W  = 5;
  localparam int unsigned PAIR_W = 16;
  localparam int unsigned HALF_W = 8;
  localparam int unsigned SIZE_W = 14;
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned REG_W  = 3;

  localparam int unsigned MAX_DIM_DEF      = 4096;
  localparam int unsigned MAX_CHANNELS_DEF = 1024;
  localparam int unsigned MAX_KERNEL_DEF   = 16;

  localparam logic [REG_W-1:0] REG_CHANNELS      = 3'd0;
  localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [REG_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [REG_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [REG_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [REG_W-1:0] REG_PAD_PAIR      = 3'd5;
  localparam logic [REG_W-1:0] REG_STRIDE_PAIR   = 3'd6;
  localparam logic [REG_W-1:0] REG_DILATION_PAIR = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]   channels;
    logic [DIM_W-1:0]  image_height;
    logic [DIM_W-1:0]  image_width;
    logic [KER_W-1:0]  kernel_height;
    logic [KER_W-1:0]  kernel_width;
    logic [PAIR_W-1:0] pad_pair;
    logic [PAIR_W-1:0] stride_pair;
    logic [PAIR_W-1:0] dilation_pair;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    channels:      CH_W'(1),
    image_height:  DIM_W'(1),
    image_width:   DIM_W'(1),
    kernel_height: KER_W'(1),
    kernel_width:  KER_W'(1),
    pad_pair:      PAIR_W'(0),
    stride_pair:   PAIR_W'(257),
    dilation_pair: PAIR_W'(257)
  };

  typedef struct packed {
    logic walk_start;
    logic size_load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_active;
    logic div_done;
    logic out_busy;
  } ctrl_status_t;

endpackage

[rtl/im2col_ifs.sv]
interface im2col_step_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface im2col_result_if import im2col_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] source_index;
  logic             zero_fill;
  logic [IDX_W-1:0] dest_index;
  logic             last;
  modport source (output valid, output source_index, output zero_fill, output dest_index,
                  output last, input ready);
  modport sink (input valid, input source_index, input zero_fill, input dest_index,
                input last, output ready);
endinterface

[rtl/im2col_address_generator_unit.sv]
// im2col address generator
// step_i takes one item per element of the column matrix; restart = 1 begins
// a new walk, restart = 0 advances. result_o gives the element's source
// index, zero-fill flag, column matrix index and last-of-walk flag.
// configuration registers sit on the apb port at byte address 4*i; the user
// must write them only while no item is in flight, the block does not enforce it.
// an item that continues a walk runs through a five stage multiply/add
// pipeline and then the output register; the next item is taken only after
// the previous one has been placed in the output register.
// an item that starts a walk (restart, or the previous walk has ended) first
// waits while two 14-bit restoring dividers find the output height and width,
// one quotient bit per cycle.
// the result register holds an item until it is taken; while the receiver
// stalls the block still takes the next item and runs it through the
// pipeline, then waits with step_i.ready low.
// reset returns all configuration registers to their defaults and clears the walk, so the
// first item after reset starts a walk.
module im2col_address_generator_unit import im2col_pkg::*; #(
  parameter int unsigned MAX_DIM      = MAX_DIM_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int unsigned MAX_KERNEL   = MAX_KERNEL_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  im2col_step_if.sink       step_i,
  im2col_result_if.source   result_o
);

  cfg_t             cfg_q, cfg_d;
  logic [REG_W-1:0] reg_sel;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  ctrl_status_t     status;

  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_CHANNELS:      cfg_d.channels      = pwdata[CH_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_d.image_height  = pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:   cfg_d.image_width   = pwdata[DIM_W-1:0];
        REG_KERNEL_HEIGHT: cfg_d.kernel_height = pwdata[KER_W-1:0];
        REG_KERNEL_WIDTH:  cfg_d.kernel_width  = pwdata[KER_W-1:0];
        REG_PAD_PAIR:      cfg_d.pad_pair      = pwdata[PAIR_W-1:0];
        REG_STRIDE_PAIR:   cfg_d.stride_pair   = pwdata[PAIR_W-1:0];
        REG_DILATION_PAIR: cfg_d.dilation_pair = pwdata[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHANNELS:      prdata = DATA_W'(cfg_q.channels);
      REG_IMAGE_HEIGHT:  prdata = DATA_W'(cfg_q.image_height);
      REG_IMAGE_WIDTH:   prdata = DATA_W'(cfg_q.image_width);
      REG_KERNEL_HEIGHT: prdata = DATA_W'(cfg_q.kernel_height);
      REG_KERNEL_WIDTH:  prdata = DATA_W'(cfg_q.kernel_width);
      REG_PAD_PAIR:      prdata = DATA_W'(cfg_q.pad_pair);
      REG_STRIDE_PAIR:   prdata = DATA_W'(cfg_q.stride_pair);
      REG_DILATION_PAIR: prdata = DATA_W'(cfg_q.dilation_pair);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  im2col_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_valid_i   (step_i.valid),
    .step_restart_i (step_i.restart),
    .step_ready_o   (step_i.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  im2col_dpath #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .source_index_o (result_o.source_index),
    .zero_fill_o    (result_o.zero_fill),
    .dest_index_o   (result_o.dest_index),
    .last_o         (result_o.last)
  );

endmodule

[rtl/im2col_div.sv]
module im2col_div #(
  parameter int unsigned NUM_W = 14,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CNT_W'(NUM_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      run_d = cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = !run_q;
  assign quot_o = quo_q;

endmodule

[rtl/im2col_dpath.sv]
module im2col_dpath import im2col_pkg::*; #(
  parameter int unsigned MAX_DIM      = MAX_DIM_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int unsigned MAX_KERNEL   = MAX_KERNEL_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  ctrl_cmd_t        cmd_i,
  output ctrl_status_t     status_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IDX_W-1:0] source_index_o,
  output logic             zero_fill_o,
  output logic [IDX_W-1:0] dest_index_o,
  output logic             last_o
);

  localparam int unsigned NUMS_W = 16;
  localparam int unsigned RS_W   = SIZE_W + HALF_W;
  localparam int unsigned RD_W   = KER_W + HALF_W;
  localparam int unsigned ROW_W  = RS_W + 2;
  localparam int unsigned CIH_W  = CH_W + DIM_W;
  localparam int unsigned CKH_W  = CH_W + KER_W;
  localparam int unsigned KRKW_W = 2 * KER_W;
  localparam int unsigned T1_W   = CKH_W + KER_W + 1;

  logic [CH_W-1:0]   nc;
  logic [DIM_W-1:0]  ih, iw;
  logic [KER_W-1:0]  kh, kw;
  logic [HALF_W-1:0] ph, pw, sh, sw, dh, dw;

  logic [NUMS_W-1:0] num_h, num_w;
  logic [SIZE_W-1:0] quot_h, quot_w;
  logic              done_h, done_w;

  logic [CH_W-1:0]   chc_q, chc_d;
  logic [KER_W-1:0]  krc_q, krc_d, kcc_q, kcc_d;
  logic [SIZE_W-1:0] orc_q, orc_d, occ_q, occ_d;
  logic [SIZE_W-1:0] oh_q, oh_d, ow_q, ow_d;
  logic              walk_q, walk_d;

  logic [RS_W-1:0]   rs_q, cs_q;
  logic [RD_W-1:0]   rd_q, cd_q;
  logic [CIH_W-1:0]  cih_q;
  logic [CKH_W-1:0]  ckh_q;
  logic [KRKW_W-1:0] krkw_q;
  logic [ROW_W-1:0]  row_q, col_q;
  logic [IDX_W-1:0]  cihw_q;
  logic [T1_W-1:0]   t1_q;
  logic              pad_q;
  logic [IDX_W-1:0]  rw_q, t2_q, src_q, t3_q, dst_q;

  logic              empty;
  logic              wrap_oc, wrap_or, wrap_kc, wrap_kr, wrap_ch, last_elem;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_src_q, out_dst_q;
  logic             out_zf_q, out_last_q;

  always_comb begin
    nc = (32'(cfg_i.channels) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : cfg_i.channels;
    ih = (32'(cfg_i.image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_i.image_height;
    iw = (32'(cfg_i.image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_i.image_width;
    kh = (32'(cfg_i.kernel_height) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) : cfg_i.kernel_height;
    kw = (32'(cfg_i.kernel_width) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) : cfg_i.kernel_width;
    ph = cfg_i.pad_pair[PAIR_W-1:HALF_W];
    pw = cfg_i.pad_pair[HALF_W-1:0];
    sh = cfg_i.stride_pair[PAIR_W-1:HALF_W];
    sw = cfg_i.stride_pair[HALF_W-1:0];
    dh = cfg_i.dilation_pair[PAIR_W-1:HALF_W];
    dw = cfg_i.dilation_pair[HALF_W-1:0];
    if (sh == '0) sh = HALF_W'(1);
    if (sw == '0) sw = HALF_W'(1);
    if (dh == '0) dh = HALF_W'(1);
    if (dw == '0) dw = HALF_W'(1);
  end

  // dim + 2*pad - (dil*(k-1) + 1)
  assign num_h = NUMS_W'(ih) + NUMS_W'({ph, 1'b0})
               - NUMS_W'(dh) * NUMS_W'(kh - KER_W'(1)) - NUMS_W'(1);
  assign num_w = NUMS_W'(iw) + NUMS_W'({pw, 1'b0})
               - NUMS_W'(dw) * NUMS_W'(kw - KER_W'(1)) - NUMS_W'(1);

  im2col_div #(.NUM_W(SIZE_W), .DEN_W(HALF_W)) u_div_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.walk_start),
    .num_i   (num_h[SIZE_W-1:0]),
    .den_i   (sh),
    .done_o  (done_h),
    .quot_o  (quot_h)
  );

  im2col_div #(.NUM_W(SIZE_W), .DEN_W(HALF_W)) u_div_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.walk_start),
    .num_i   (num_w[SIZE_W-1:0]),
    .den_i   (sw),
    .done_o  (done_w),
    .quot_o  (quot_w)
  );

  // stage 1
  always_ff @(posedge clk_i) begin
    rs_q   <= RS_W'(orc_q) * RS_W'(sh);
    cs_q   <= RS_W'(occ_q) * RS_W'(sw);
    rd_q   <= RD_W'(krc_q) * RD_W'(dh);
    cd_q   <= RD_W'(kcc_q) * RD_W'(dw);
    cih_q  <= CIH_W'(chc_q) * CIH_W'(ih);
    ckh_q  <= CKH_W'(chc_q) * CKH_W'(kh);
    krkw_q <= KRKW_W'(krc_q) * KRKW_W'(kw);
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    row_q  <= ROW_W'(rs_q) + ROW_W'(rd_q) - ROW_W'(ph);
    col_q  <= ROW_W'(cs_q) + ROW_W'(cd_q) - ROW_W'(pw);
    cihw_q <= IDX_W'(cih_q) * IDX_W'(iw);
    t1_q   <= T1_W'(ckh_q) * T1_W'(kw) + T1_W'(krkw_q) + T1_W'(kcc_q);
  end

  // stage 3, negative positions wrap above the bound
  always_ff @(posedge clk_i) begin
    pad_q <= (row_q >= ROW_W'(ih)) || (col_q >= ROW_W'(iw));
    rw_q  <= IDX_W'(row_q[DIM_W-1:0]) * IDX_W'(iw);
    t2_q  <= IDX_W'(t1_q) * IDX_W'(oh_q);
  end

  // stage 4
  always_ff @(posedge clk_i) begin
    src_q <= cihw_q + rw_q + IDX_W'(col_q[DIM_W-1:0]);
    t3_q  <= t2_q + IDX_W'(orc_q);
  end

  // stage 5
  always_ff @(posedge clk_i) begin
    dst_q <= t3_q * IDX_W'(ow_q) + IDX_W'(occ_q);
  end

  always_comb begin
    empty   = (nc == '0) || (kh == '0) || (kw == '0) || (oh_q == '0) || (ow_q == '0);
    wrap_oc = (SIZE_W + 1)'(occ_q) + (SIZE_W + 1)'(1) >= (SIZE_W + 1)'(ow_q);
    wrap_or = (SIZE_W + 1)'(orc_q) + (SIZE_W + 1)'(1) >= (SIZE_W + 1)'(oh_q);
    wrap_kc = (KER_W + 1)'(kcc_q) + (KER_W + 1)'(1) >= (KER_W + 1)'(kw);
    wrap_kr = (KER_W + 1)'(krc_q) + (KER_W + 1)'(1) >= (KER_W + 1)'(kh);
    wrap_ch = (CH_W + 1)'(chc_q) + (CH_W + 1)'(1) >= (CH_W + 1)'(nc);
    last_elem = wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_ch;

    chc_d  = chc_q;
    krc_d  = krc_q;
    kcc_d  = kcc_q;
    orc_d  = orc_q;
    occ_d  = occ_q;
    oh_d   = oh_q;
    ow_d   = ow_q;
    walk_d = walk_q;

    if (cmd_i.walk_start) begin
      chc_d  = '0;
      krc_d  = '0;
      kcc_d  = '0;
      orc_d  = '0;
      occ_d  = '0;
      walk_d = 1'b1;
    end

    if (cmd_i.size_load) begin
      oh_d = (num_h[NUMS_W-1] || kh == '0) ? '0 : quot_h + SIZE_W'(1);
      ow_d = (num_w[NUMS_W-1] || kw == '0) ? '0 : quot_w + SIZE_W'(1);
    end

    if (cmd_i.emit) begin
      if (empty) begin
        chc_d  = '0;
        krc_d  = '0;
        kcc_d  = '0;
        orc_d  = '0;
        occ_d  = '0;
        walk_d = 1'b0;
      end else begin
        occ_d = wrap_oc ? '0 : occ_q + SIZE_W'(1);
        if (wrap_oc) begin
          orc_d = wrap_or ? '0 : orc_q + SIZE_W'(1);
          if (wrap_or) begin
            kcc_d = wrap_kc ? '0 : kcc_q + KER_W'(1);
            if (wrap_kc) begin
              krc_d = wrap_kr ? '0 : krc_q + KER_W'(1);
              if (wrap_kr) begin
                chc_d = wrap_ch ? '0 : chc_q + CH_W'(1);
              end
            end
          end
        end
        if (last_elem) begin
          walk_d = 1'b0;
        end
      end
    end

    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chc_q       <= '0;
      krc_q       <= '0;
      kcc_q       <= '0;
      orc_q       <= '0;
      occ_q       <= '0;
      oh_q        <= '0;
      ow_q        <= '0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      chc_q       <= chc_d;
      krc_q       <= krc_d;
      kcc_q       <= kcc_d;
      orc_q       <= orc_d;
      occ_q       <= occ_d;
      oh_q        <= oh_d;
      ow_q        <= ow_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (empty) begin
        out_src_q  <= '0;
        out_zf_q   <= 1'b1;
        out_dst_q  <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_src_q  <= pad_q ? '0 : src_q;
        out_zf_q   <= pad_q;
        out_dst_q  <= dst_q;
        out_last_q <= last_elem;
      end
    end
  end

  assign status_o.walk_active = walk_q;
  assign status_o.div_done    = done_h && done_w;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign source_index_o = out_src_q;
  assign zero_fill_o    = out_zf_q;
  assign dest_index_o   = out_dst_q;
  assign last_o         = out_last_q;

endmodule

[rtl/im2col_ctrl.sv]
module im2col_ctrl import im2col_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_valid_i,
  input  logic         step_restart_i,
  output logic         step_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    step_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        step_ready_o = 1'b1;
        if (step_valid_i) begin
          if (step_restart_i || !status_i.walk_active) begin
            cmd_o.walk_start = 1'b1;
            state_d          = S_DIV;
          end else begin
            state_d = S_M1;
          end
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.size_load = 1'b1;
          state_d         = S_M1;
        end
      end
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: state_d = S_M5;
      S_M5: state_d = S_OUT;
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
